@@ src/hvt_pkg.sv @@
// ----------------------------------------------------------------------------
// hvt_pkg: shared types and constants
// Widths, latencies and result type of the homogeneous vertex transform.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int NEAR_ZERO_LIMIT = 1;

  localparam int EW     = 32;             // element / component width
  localparam int PW     = 2 * EW;         // product width
  localparam int SUMW   = PW + 2;         // sum of four products
  localparam int SW     = SUMW - FRAC_BITS; // row sum after floor
  localparam int NW     = SW + FRAC_BITS; // scaled numerator magnitude
  localparam int QW     = EW;             // quotient bits formed
  localparam int DW     = SW + QW;        // widest shifted divisor
  localparam int NPAIRS = 8;
  localparam int IDXW   = 4;
  localparam int CFGW   = 2 * EW;

  localparam int ROW_LAT = 2;
  localparam int DIV_LAT = QW + 2;
  localparam int LAT     = ROW_LAT + DIV_LAT;

  localparam logic [CFGW-1:0] PAIR_RESET [NPAIRS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  typedef struct packed {
    logic [EW-1:0] val;
    logic          sat;
    logic          divided;
  } hvt_res_t;

endpackage

@@ src/hvt_row_lane.sv @@
// ----------------------------------------------------------------------------
// hvt_row_lane: one matrix row
// Four products in one stage, then a floored sum in the next.
// ----------------------------------------------------------------------------
module hvt_row_lane (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [hvt_pkg::EW-1:0]           m0,
  input  logic signed [hvt_pkg::EW-1:0]           m1,
  input  logic signed [hvt_pkg::EW-1:0]           m2,
  input  logic signed [hvt_pkg::EW-1:0]           m3,
  input  logic signed [hvt_pkg::EW-1:0]           x,
  input  logic signed [hvt_pkg::EW-1:0]           y,
  input  logic signed [hvt_pkg::EW-1:0]           z,
  input  logic                                    is_point,
  output logic signed [hvt_pkg::SW-1:0]           sum
);

  logic signed [hvt_pkg::PW-1:0]   p0_r, p1_r, p2_r, p3_r;
  logic signed [hvt_pkg::SUMW-1:0] total;
  logic signed [hvt_pkg::SUMW-1:0] floored;
  logic signed [hvt_pkg::SW-1:0]   sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= m0 * x;
      p1_r <= m1 * y;
      p2_r <= m2 * z;
      p3_r <= is_point ? (hvt_pkg::PW'(m3) <<< hvt_pkg::FRAC_BITS) : '0;
      sum_r <= floored[hvt_pkg::SW-1:0];
    end
  end

  always_comb begin
    total   = hvt_pkg::SUMW'(p0_r) + hvt_pkg::SUMW'(p1_r)
            + hvt_pkg::SUMW'(p2_r) + hvt_pkg::SUMW'(p3_r);
    floored = total >>> hvt_pkg::FRAC_BITS;
  end

  assign sum = sum_r;

endmodule

@@ src/hvt_div_lane.sv @@
// ----------------------------------------------------------------------------
// hvt_div_lane: perspective divide of one component
// Pipelined restoring divider, one quotient bit a stage, then saturation.
// ----------------------------------------------------------------------------
module hvt_div_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [hvt_pkg::SW-1:0] s,
  input  logic signed [hvt_pkg::SW-1:0] s3,
  output hvt_pkg::hvt_res_t             res
);

  localparam int QW = hvt_pkg::QW;

  typedef struct packed {
    logic                 near;
    logic                 neg;
    logic                 big;
    logic [hvt_pkg::EW-1:0] nval;
    logic                 nsat;
  } ctl_t;

  logic [hvt_pkg::NW-1:0] rem_r [QW+1];
  logic [QW-1:0]          q_r   [QW+1];
  logic [hvt_pkg::SW-1:0] den_r [QW+1];
  ctl_t                   ctl_r [QW+1];
  hvt_pkg::hvt_res_t      res_r;

  logic [hvt_pkg::SW-1:0] a_mag, b_mag;
  logic [hvt_pkg::NW-1:0] num;
  ctl_t                   ctl0;

  always_comb begin
    a_mag = s[hvt_pkg::SW-1]  ? hvt_pkg::SW'(-s)  : s;
    b_mag = s3[hvt_pkg::SW-1] ? hvt_pkg::SW'(-s3) : s3;
    num   = {a_mag, {hvt_pkg::FRAC_BITS{1'b0}}};
    ctl0.near = b_mag <= hvt_pkg::SW'(hvt_pkg::NEAR_ZERO_LIMIT);
    ctl0.neg  = s[hvt_pkg::SW-1] ^ s3[hvt_pkg::SW-1];
    ctl0.big  = hvt_pkg::DW'(num) >= {b_mag, {QW{1'b0}}};
    if (s > hvt_pkg::SW'(signed'(32'sh7fffffff))) begin
      ctl0.nsat = 1'b1;
      ctl0.nval = 32'h7fffffff;
    end else if (s < hvt_pkg::SW'(signed'(32'sh80000000))) begin
      ctl0.nsat = 1'b1;
      ctl0.nval = 32'h80000000;
    end else begin
      ctl0.nsat = 1'b0;
      ctl0.nval = s[hvt_pkg::EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      q_r[0]   <= '0;
      den_r[0] <= b_mag;
      ctl_r[0] <= ctl0;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic [hvt_pkg::DW:0] diff;
    logic                 ge;
    always_comb begin
      diff = {1'b0, hvt_pkg::DW'(rem_r[i])}
           - {1'b0, hvt_pkg::DW'(den_r[i]) << K};
      ge   = ~diff[hvt_pkg::DW];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? diff[hvt_pkg::NW-1:0] : rem_r[i];
        q_r[i+1]   <= q_r[i] | (QW'(ge) << K);
        den_r[i+1] <= den_r[i];
        ctl_r[i+1] <= ctl_r[i];
      end
    end
  end

  hvt_pkg::hvt_res_t res_nxt;
  ctl_t              cl;
  logic [QW-1:0]     qf;

  always_comb begin
    cl = ctl_r[QW];
    qf = q_r[QW];
    res_nxt.divided = ~cl.near;
    if (cl.near) begin
      res_nxt.sat = cl.nsat;
      res_nxt.val = cl.nval;
    end else if (cl.neg) begin
      res_nxt.sat = cl.big || (qf > 32'h80000000);
      res_nxt.val = res_nxt.sat ? 32'h80000000 : (~qf + 32'd1);
    end else begin
      res_nxt.sat = cl.big || qf[QW-1];
      res_nxt.val = res_nxt.sat ? 32'h7fffffff : qf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ src/homogeneous_vertex_transform_unit.sv @@
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_unit: 4x4 transform with perspective divide
// Stages: products, row sums, divide input, quotient bits, saturation.
// Throughput: one beat per cycle; the pipeline halts as a whole while a
// result waits. Synchronous active-low reset clears the valid pipeline and
// loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hvt_pkg::IDXW-1:0]          cfg_index,
  input  logic [hvt_pkg::CFGW-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hvt_pkg::EW-1:0]     in_x,
  input  logic signed [hvt_pkg::EW-1:0]     in_y,
  input  logic signed [hvt_pkg::EW-1:0]     in_z,
  input  logic                              in_is_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hvt_pkg::EW-1:0]     out_x,
  output logic signed [hvt_pkg::EW-1:0]     out_y,
  output logic signed [hvt_pkg::EW-1:0]     out_z,
  output logic                              out_w_divided,
  output logic                              out_saturated
);

  logic [hvt_pkg::CFGW-1:0]       pair_r [hvt_pkg::NPAIRS];
  logic signed [hvt_pkg::EW-1:0]  elem   [16];
  logic [hvt_pkg::LAT-1:0]        vld_r;
  logic                           en;
  logic signed [hvt_pkg::SW-1:0]  sum    [4];
  hvt_pkg::hvt_res_t              res    [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < hvt_pkg::NPAIRS; p++) pair_r[p] <= hvt_pkg::PAIR_RESET[p];
    end else if (cfg_we && (cfg_index < hvt_pkg::IDXW'(hvt_pkg::NPAIRS))) begin
      pair_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      elem[k] = pair_r[k/2][(k%2)*hvt_pkg::EW +: hvt_pkg::EW];
    end
  end

  assign en       = ~vld_r[hvt_pkg::LAT-1] | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[hvt_pkg::LAT-2:0], in_valid};
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    hvt_row_lane u_row (
      .clk      (clk),
      .en       (en),
      .m0       (elem[r]),
      .m1       (elem[4+r]),
      .m2       (elem[8+r]),
      .m3       (elem[12+r]),
      .x        (in_x),
      .y        (in_y),
      .z        (in_z),
      .is_point (in_is_point),
      .sum      (sum[r])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    hvt_div_lane u_div (
      .clk (clk),
      .en  (en),
      .s   (sum[c]),
      .s3  (sum[3]),
      .res (res[c])
    );
  end

  assign out_valid     = vld_r[hvt_pkg::LAT-1];
  assign out_x         = res[0].val;
  assign out_y         = res[1].val;
  assign out_z         = res[2].val;
  assign out_w_divided = res[0].divided;
  assign out_saturated = res[0].sat | res[1].sat | res[2].sat;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted beat did not enter pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(vld_r))
    else $error("pipeline moved during output stall");

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (res[0].divided == res[1].divided) && (res[1].divided == res[2].divided))
    else $error("divide lanes disagree on near-zero w");

endmodule

@@ tb/sv/homogeneous_vertex_transform_unit_tb.sv @@
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_unit_tb: self-checking testbench
// Drives vectors through the 4x4 transform with perspective divide, predicts
// each result in fixed point and compares it with the result beat. Covers
// identity, projective and extreme matrices, near-zero w, saturation and
// output backpressure.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [hvt_pkg::EW-1:0] x, y, z;
    logic                   divided, sat;
  } vtx_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [hvt_pkg::IDXW-1:0] cfg_index = '0;
  logic [hvt_pkg::CFGW-1:0] cfg_data = '0;
  logic in_valid = 0, in_is_point = 0;
  logic signed [hvt_pkg::EW-1:0] in_x = 0, in_y = 0, in_z = 0;
  logic in_ready, out_valid, out_w_divided, out_saturated;
  logic out_ready = 0;
  logic signed [hvt_pkg::EW-1:0] out_x, out_y, out_z;

  logic [hvt_pkg::CFGW-1:0] mtx_pairs [hvt_pkg::NPAIRS];
  vtx_t expected_q [$];
  int errors = 0, beats_in = 0, beats_out = 0, n_div = 0, n_sat = 0;
  int burst_left = 0;
  bit hold_off = 0;

  homogeneous_vertex_transform_unit u_top (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint elem_of(int k);
    logic [hvt_pkg::CFGW-1:0] p;
    p = mtx_pairs[k/2];
    return (k % 2) ? longint'(signed'(p[63:32])) : longint'(signed'(p[31:0]));
  endfunction

  function automatic logic signed [hvt_pkg::SW-1:0] row_of(int r, longint v[4]);
    logic signed [hvt_pkg::SUMW-1:0] acc;
    acc = 0;
    for (int c = 0; c < 4; c++)
      acc += hvt_pkg::SUMW'(elem_of(4*c + r)) * hvt_pkg::SUMW'(v[c]);
    return hvt_pkg::SW'(acc >>> hvt_pkg::FRAC_BITS);
  endfunction

  function automatic logic [hvt_pkg::EW-1:0] clamp32(logic signed [127:0] v,
      inout logic sat);
    if (v > 128'sd2147483647) begin sat = 1; return 32'h7fffffff; end
    if (v < -128'sd2147483648) begin sat = 1; return 32'h80000000; end
    return v[31:0];
  endfunction

  function automatic logic [hvt_pkg::EW-1:0] divide_by_w(
      logic signed [hvt_pkg::SW-1:0] num,
      logic signed [hvt_pkg::SW-1:0] den, inout logic sat);
    logic [127:0] a, b, q;
    logic neg;
    neg = (num < 0) != (den < 0);
    a = num < 0 ? 128'(-num) : 128'(num);
    b = den < 0 ? 128'(-den) : 128'(den);
    q = (a << hvt_pkg::FRAC_BITS) / b;
    if (neg) begin
      if (q > 128'd2147483648) begin sat = 1; q = 128'd2147483648; end
      return 32'(-q);
    end
    if (q > 128'd2147483647) begin sat = 1; q = 128'd2147483647; end
    return q[31:0];
  endfunction

  function automatic vtx_t transform_vertex(logic [hvt_pkg::EW-1:0] x, y, z, logic pt);
    longint v[4];
    logic signed [hvt_pkg::SW-1:0] s[4];
    logic signed [hvt_pkg::SW-1:0] wmag;
    vtx_t e;
    v[0] = longint'(signed'(x)); v[1] = longint'(signed'(y));
    v[2] = longint'(signed'(z)); v[3] = pt ? (64'sd1 << hvt_pkg::FRAC_BITS) : 0;
    for (int r = 0; r < 4; r++) s[r] = row_of(r, v);
    wmag = s[3] < 0 ? -s[3] : s[3];
    e.sat = 0;
    e.divided = !(wmag <= hvt_pkg::NEAR_ZERO_LIMIT);
    if (!e.divided) begin
      e.x = clamp32(128'(s[0]), e.sat);
      e.y = clamp32(128'(s[1]), e.sat);
      e.z = clamp32(128'(s[2]), e.sat);
    end else begin
      e.x = divide_by_w(s[0], s[3], e.sat);
      e.y = divide_by_w(s[1], s[3], e.sat);
      e.z = divide_by_w(s[2], s[3], e.sat);
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [hvt_pkg::EW-1:0] got, want);
    errors++;
    $display("mismatch %s at result %0d: got %h want %h", what, beats_out, got, want);
  endtask

  // receiver: random stall pattern, long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 7) < 2) ? 0 : ($urandom_range(0, 9) != 0);
  end

  always @(posedge clk) begin
    vtx_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_x, '0);
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x) report_mismatch("x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("y", out_y, e.y);
        if (out_z !== e.z) report_mismatch("z", out_z, e.z);
        if (out_w_divided !== e.divided)
          report_mismatch("w_divided", out_w_divided, e.divided);
        if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
        n_div += e.divided;
        n_sat += e.sat;
      end
    end
  end

  task automatic send_vertex(logic [hvt_pkg::EW-1:0] x, y, z, logic pt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1; in_x <= x; in_y <= y; in_z <= z; in_is_point <= pt;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(transform_vertex(x, y, z, pt));
    beats_in++;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (hvt_pkg::LAT + 8) @(posedge clk);
  endtask

  task automatic write_pair(int idx, logic [hvt_pkg::CFGW-1:0] val);
    cfg_we <= 1; cfg_index <= hvt_pkg::IDXW'(idx); cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx < hvt_pkg::NPAIRS) mtx_pairs[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [hvt_pkg::EW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 40)) - 20) : '0;
      3: return 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [hvt_pkg::EW-1:0] rand_elem();
    case ($urandom_range(0, 4))
      0: return 32'(int'($urandom_range(0, 4 << 16)) - (2 << 16));
      1: return $urandom_range(0, 1) ? 32'h00010000 : '0;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_identity_directed;
    send_vertex(0, 0, 0, 1);
    send_vertex(0, 0, 0, 0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h00010000, 1);
    send_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 0);
    send_vertex(32'hffffffff, 32'h00000001, 32'h55555555, 1);
    send_vertex(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 0);
    drain();
  endtask

  task automatic test_projective_directed;
    // w from z, near-zero and tiny divisors
    write_pair(7, {32'h00000000, 32'h00010000});
    write_pair(5, {32'h00010000, 32'h00010000});
    send_vertex(32'h00020000, 32'h00030000, 32'h00020000, 0);
    send_vertex(32'h00020000, 32'h00030000, 32'h00000001, 0);
    send_vertex(32'h00020000, 32'h00030000, 32'hffffffff, 0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h00000002, 0);
    send_vertex(32'h7fffffff, 32'h80000000, 32'hfffffffe, 0);
    send_vertex(32'h00010000, 32'h00010000, 32'h00000000, 1);
    send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    drain();
    write_pair(9, '1);
    for (int i = 0; i < hvt_pkg::NPAIRS; i++) write_pair(i, '1);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0);
    drain();
    for (int i = 0; i < hvt_pkg::NPAIRS; i++) write_pair(i, {32'h80000000, 32'h80000000});
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1);
    send_vertex(32'h7fffffff, 32'h00000000, 32'h80000000, 0);
    drain();
    for (int i = 0; i < hvt_pkg::NPAIRS; i++) write_pair(i, '0);
  endtask

  task automatic test_random_matrices;
    for (int ph = 0; ph < 12; ph++) begin
      for (int i = 0; i < hvt_pkg::NPAIRS; i++)
        write_pair(i, (ph == 0) ? hvt_pkg::PAIR_RESET[i] : {rand_elem(), rand_elem()});
      repeat (110) send_vertex(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 1));
      drain();
    end
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      repeat (100) send_vertex(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 1));
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < hvt_pkg::NPAIRS; i++) mtx_pairs[i] = hvt_pkg::PAIR_RESET[i];
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_identity_directed();
    test_projective_directed();
    test_backpressure();
    test_random_matrices();
    $display("%0d vertices in, %0d results checked (%0d divided by w, %0d clamped)",
             beats_in, beats_out, n_div, n_sat);
    if (errors == 0 && expected_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ files.f @@
src/hvt_pkg.sv
src/hvt_row_lane.sv
src/hvt_div_lane.sv
src/homogeneous_vertex_transform_unit.sv
tb/sv/homogeneous_vertex_transform_unit_tb.sv
